// ----- rtl/config_text_tokenizer_assert.svh -----
// ---------------------------------------------------------------------------
// config_text_tokenizer assertion macros
// Concurrent assertion shorthands shared by the tokenizer RTL.
// ---------------------------------------------------------------------------
`ifndef CONFIG_TEXT_TOKENIZER_ASSERT_SVH
`define CONFIG_TEXT_TOKENIZER_ASSERT_SVH

// condition and consequence in the same cycle
`define CTT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define CTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ctt_pkg.sv -----
// ---------------------------------------------------------------------------
// ctt_pkg
// Shared types and character codes of the configuration text tokenizer.
// ---------------------------------------------------------------------------
package ctt_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// result queue geometry
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef enum logic [1:0] {
		QM_NONE   = 2'd0,
		QM_SINGLE = 2'd1,
		QM_DOUBLE = 2'd2
	} quote_mode_t;

	typedef struct packed {
		logic [7:0]  out_char;
		logic        has_char;
		logic        token_end;
		logic        token_dropped;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic        run_last;
	} result_t;

	// results produced by one input transaction
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} lex_out_t;

endpackage

// ----- rtl/ctt_lexer.sv -----
// ---------------------------------------------------------------------------
// ctt_lexer
// Lexer state and combinational decode of one byte into zero to two results.
// ---------------------------------------------------------------------------
module ctt_lexer #(
	parameter int MAX_TOKEN_LEN  = 256,
	parameter int POSITION_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        ch,
	input  logic              eoi,
	output ctt_pkg::lex_out_t lex
);
	import ctt_pkg::*;

	localparam int TLW = $clog2(MAX_TOKEN_LEN + 1);

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_APPEND,
		ACT_CLOSE,
		ACT_SEMI
	} act_t;

	logic [TLW-1:0]            tl_q, tl_n, tl_inc;
	logic                      esc_q, esc_n;
	quote_mode_t               qm_q, qm_n;
	logic                      cmt_q, cmt_n;
	logic [POSITION_WIDTH-1:0] line_q, line_n, col_q, col_n;
	logic [POSITION_WIDTH-1:0] tline_q, tline_n, tcol_q, tcol_n;
	logic                      nonempty, cut, is_lb;
	logic [15:0]               pos_line, pos_col;
	act_t                      act;

	function automatic logic [15:0] sat_pos(input logic [POSITION_WIDTH-1:0] v);
		logic [32:0] w;
		w = 33'(v);
		return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	always_comb begin
		tl_n    = tl_q;
		esc_n   = esc_q;
		qm_n    = qm_q;
		cmt_n   = cmt_q;
		line_n  = line_q;
		col_n   = col_q;
		tline_n = tline_q;
		tcol_n  = tcol_q;
		lex     = '0;
		act     = ACT_NONE;

		nonempty = (tl_q != '0);
		tl_inc   = TLW'(tl_q + 1'b1);
		cut      = (tl_inc >= TLW'(MAX_TOKEN_LEN));
		is_lb    = (ch == CH_LF) || (ch == CH_CR);
		pos_line = sat_pos(tline_q);
		pos_col  = sat_pos(tcol_q);

		if (eoi) begin
			lex.count            = 2'd1;
			lex.r0.token_dropped = nonempty;
			lex.r0.start_line    = nonempty ? pos_line : 16'd0;
			lex.r0.start_column  = nonempty ? pos_col : 16'd0;
			lex.r0.run_last      = 1'b1;
			tl_n    = '0;
			esc_n   = 1'b0;
			qm_n    = QM_NONE;
			cmt_n   = 1'b0;
			line_n  = '0;
			col_n   = '0;
			tline_n = '0;
			tcol_n  = '0;
		end else begin
			if (is_lb) begin
				col_n = '0;
				if (!(&line_q))
					line_n = line_q + 1'b1;
			end else if (!(&col_q)) begin
				col_n = col_q + 1'b1;
			end

			if (is_lb && cmt_q) begin
				// line break only ends the comment
				cmt_n = 1'b0;
			end else begin
				if (!nonempty) begin
					tline_n = line_n;
					tcol_n  = col_n;
				end
				pos_line = sat_pos(tline_n);
				pos_col  = sat_pos(tcol_n);

				if (cmt_q) begin
					act = ACT_NONE;
				end else if (ch == CH_NUL) begin
					if (nonempty)
						act = ACT_CLOSE;
				end else if (esc_q) begin
					esc_n = 1'b0;
					act   = ACT_APPEND;
				end else if (qm_q == QM_DOUBLE && ch == CH_DQUOTE) begin
					qm_n = QM_NONE;
				end else if (qm_q == QM_SINGLE && ch == CH_SQUOTE) begin
					qm_n = QM_NONE;
				end else if (qm_q != QM_NONE) begin
					act = ACT_APPEND;
				end else if (ch == CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (ch == CH_DQUOTE) begin
					qm_n = QM_DOUBLE;
				end else if (ch == CH_SQUOTE) begin
					qm_n = QM_SINGLE;
				end else if (ch inside {CH_CR, CH_LF, CH_SPACE, CH_TAB}) begin
					if (nonempty)
						act = ACT_CLOSE;
				end else if (ch == CH_HASH) begin
					cmt_n = 1'b1;
				end else if (ch == CH_SEMI) begin
					act = ACT_SEMI;
				end else begin
					act = ACT_APPEND;
				end
			end

			case (act)
				ACT_APPEND: begin
					lex.count           = 2'd1;
					lex.r0.out_char     = ch;
					lex.r0.has_char     = 1'b1;
					lex.r0.token_end    = cut;
					lex.r0.start_line   = pos_line;
					lex.r0.start_column = pos_col;
					lex.r0.run_last     = 1'b1;
					if (cut) begin
						tl_n  = '0;
						esc_n = 1'b0;
						qm_n  = QM_NONE;
						cmt_n = 1'b0;
					end else begin
						tl_n = tl_inc;
					end
				end
				ACT_CLOSE: begin
					lex.count           = 2'd1;
					lex.r0.token_end    = 1'b1;
					lex.r0.start_line   = pos_line;
					lex.r0.start_column = pos_col;
					lex.r0.run_last     = 1'b1;
					tl_n  = '0;
					esc_n = 1'b0;
					qm_n  = QM_NONE;
					cmt_n = 1'b0;
				end
				ACT_SEMI: begin
					if (nonempty) begin
						// close the open token, then the semicolon token at its own spot
						lex.count           = 2'd2;
						lex.r0.token_end    = 1'b1;
						lex.r0.start_line   = pos_line;
						lex.r0.start_column = pos_col;
						lex.r1.out_char     = CH_SEMI;
						lex.r1.has_char     = 1'b1;
						lex.r1.token_end    = 1'b1;
						lex.r1.start_line   = sat_pos(line_n);
						lex.r1.start_column = sat_pos(col_n);
						lex.r1.run_last     = 1'b1;
						tline_n = line_n;
						tcol_n  = col_n;
					end else begin
						lex.count           = 2'd1;
						lex.r0.out_char     = CH_SEMI;
						lex.r0.has_char     = 1'b1;
						lex.r0.token_end    = 1'b1;
						lex.r0.start_line   = pos_line;
						lex.r0.start_column = pos_col;
						lex.r0.run_last     = 1'b1;
					end
					tl_n  = '0;
					esc_n = 1'b0;
					qm_n  = QM_NONE;
					cmt_n = 1'b0;
				end
				default: begin
					lex.count = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q    <= '0;
			esc_q   <= 1'b0;
			qm_q    <= QM_NONE;
			cmt_q   <= 1'b0;
			line_q  <= '0;
			col_q   <= '0;
			tline_q <= '0;
			tcol_q  <= '0;
		end else if (fire) begin
			tl_q    <= tl_n;
			esc_q   <= esc_n;
			qm_q    <= qm_n;
			cmt_q   <= cmt_n;
			line_q  <= line_n;
			col_q   <= col_n;
			tline_q <= tline_n;
			tcol_q  <= tcol_n;
		end
	end

endmodule

// ----- rtl/ctt_result_fifo.sv -----
// ---------------------------------------------------------------------------
// ctt_result_fifo
// Small result queue that takes up to two results per cycle and hands out one per cycle while rd_stall is low.
// ---------------------------------------------------------------------------
module ctt_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  ctt_pkg::lex_out_t wr_data,
	output logic              room,
	output logic              rd_valid,
	input  logic              rd_stall,
	output ctt_pkg::result_t  rd_data
);
	import ctt_pkg::*;

	result_t               mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [RQ_CNT_W-1:0]   count_q;
	logic [1:0]            push;
	logic                  pop;

	assign push     = wr_en ? wr_data.count : 2'd0;
	assign rd_valid = (count_q != '0);
	assign pop      = rd_valid && !rd_stall;
	// two free slots, so a two-result transaction always fits
	assign room     = (count_q <= RQ_CNT_W'(RQ_DEPTH - 2));
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push != 2'd0)
			mem_q[wr_ptr_q] <= wr_data.r0;
		if (push == 2'd2)
			mem_q[RQ_PTR_W'(wr_ptr_q + 1'b1)] <= wr_data.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= RQ_PTR_W'(wr_ptr_q + push);
			if (pop)
				rd_ptr_q <= RQ_PTR_W'(rd_ptr_q + 1'b1);
			count_q <= RQ_CNT_W'(count_q + RQ_CNT_W'(push) - RQ_CNT_W'(pop));
		end
	end

endmodule

// ----- rtl/config_text_tokenizer.sv -----
// ---------------------------------------------------------------------------
// config_text_tokenizer
// Byte-serial shell-style lexer for configuration text.
// ---------------------------------------------------------------------------
// One text byte is taken per clock while item_stall is low. A byte is held
// in the input register until it is decoded against the lexer state, which
// is combinational, and its zero, one or two results go into a four-entry
// result queue. The result port gives one result per clock while
// result_stall is low; item_stall rises only while the queue has fewer than
// two free entries, which happens when results are stalled or when many
// semicolons that follow token bytes (two results each) arrive back to back.
// There is no clearing pass after reset.
module config_text_tokenizer #(
	parameter int MAX_TOKEN_LEN  = 256,
	parameter int POSITION_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  in_char,
	input  logic        end_of_input,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_char,
	output logic        has_char,
	output logic        token_end,
	output logic        token_dropped,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic        run_last
);
	import ctt_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;
	logic       room;
	logic       fire;
	logic       accept;
	lex_out_t   lex;
	result_t    head;

	assign fire       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= in_char;
			eoi_s1  <= end_of_input;
		end
	end

	ctt_lexer #(
		.MAX_TOKEN_LEN  (MAX_TOKEN_LEN),
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (char_s1),
		.eoi    (eoi_s1),
		.lex    (lex)
	);

	ctt_result_fifo u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fire),
		.wr_data  (lex),
		.room     (room),
		.rd_valid (result_valid),
		.rd_stall (result_stall),
		.rd_data  (head)
	);

	assign out_char      = head.out_char;
	assign has_char      = head.has_char;
	assign token_end     = head.token_end;
	assign token_dropped = head.token_dropped;
	assign start_line    = head.start_line;
	assign start_column  = head.start_column;
	assign run_last      = head.run_last;

`include "config_text_tokenizer_assert.svh"

	`CTT_ASSERT_SAME(a_stall_needs_held_byte, clk, arst_n, item_stall, valid_s1, "stall without a held byte")
	`CTT_ASSERT_NEXT(a_held_byte_kept, clk, arst_n, item_stall, valid_s1, "stalled byte was lost")
	`CTT_ASSERT_SAME(a_eoi_single_result, clk, arst_n, fire && eoi_s1, lex.count == 2'd1 && lex.r0.run_last && !lex.r0.has_char, "end of input must give one plain result")
	`CTT_ASSERT_SAME(a_pair_marks_last, clk, arst_n, fire && lex.count == 2'd2, lex.r1.run_last && !lex.r0.run_last && lex.r0.token_end, "two-result transaction marked wrong")

endmodule
